// ===== sv/kat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_pkg
// Shared types and constants for the keyed accumulator table.
// ----------------------------------------------------------------------------
package kat_pkg;

  localparam int CAPACITY  = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 31;
  localparam int AMT_W     = 31;
  localparam int DIV_W     = 31;
  localparam int SUM_W     = 32;
  localparam int SHARE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int ENTRIES_W = 6;
  localparam int NUM_W     = SUM_W + FRAC_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    REQ_ACC  = 2'd0,
    REQ_REM  = 2'd1,
    REQ_QRY  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_MOVE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
  } slot_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
  } mem_req_t;

endpackage

// ===== sv/kat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_mem
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kat_mem (
  input  logic             clk,
  input  kat_pkg::mem_req_t mem_req,
  output kat_pkg::slot_t   rd_data
);
  import kat_pkg::*;

  slot_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule

// ===== sv/kat_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_div
// Restoring divider for (sum << 16) / divisor, one quotient bit per cycle,
// saturating to all ones when the quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
module kat_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kat_pkg::SUM_W-1:0]    sum,
  input  logic [kat_pkg::DIV_W-1:0]    divisor,
  output logic                         done,
  output logic [kat_pkg::SHARE_W-1:0]  quotient
);
  import kat_pkg::*;

  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   dvs_r;
  logic [SHARE_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               sat_r;
  logic [DIV_W:0]     trial;
  logic               fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt = fits ? DIV_W'(trial - {1'b0, dvs_r}) : DIV_W'(trial);
      quo_nxt = {quo_r[SHARE_W-2:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start ? 1'b1 : busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // The quotient reaches 2^32 exactly when sum / 2^16 >= divisor.
      sat_r <= ({{(DIV_W - (SUM_W - FRAC_W)){1'b0}}, sum[SUM_W-1:FRAC_W]} >= divisor);
      num_r <= {sum, {FRAC_W{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      dvs_r <= divisor;
      cnt_r <= STEP_W'(DIV_STEPS);
    end else begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = sat_r ? {SHARE_W{1'b1}} : quo_r;

endmodule

// ===== sv/keyed_accumulator_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_accumulator_table
// Dense key/sum table with accumulate, swap-remove and share query.
// ----------------------------------------------------------------------------
// Usage: an item on the in_ channel carries a request type, a key, an amount
// and a divisor. Each accepted item gives exactly one item on the out_ channel
// with the share, found and rejected flags and the entry count after the item.
// Both channels move an item when valid is high and stall is low.
// The block handles one item at a time. in_stall is low only while idle.
// A rejected or unused request goes from idle straight to the done state.
// Otherwise the key search reads one slot per cycle from the slot memory,
// over the occupied entries only; accumulate then passes through the act
// state, a found remove through the act and move states, and a found query
// through the act state and then waits for the divider. The search and the
// divider set the rate.
// Reset clears the entry count at once; slots past the count are never read,
// so the memory needs no clearing pass and an item is taken right after reset.
// When the receiver stalls, the finished item waits in the output register;
// the block still takes the next input item, and holds it before the output
// stage until the register is free.
// ----------------------------------------------------------------------------
module keyed_accumulator_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [kat_pkg::KEY_W-1:0]     in_entry_key,
  input  logic [kat_pkg::AMT_W-1:0]     in_add_amount,
  input  logic [kat_pkg::DIV_W-1:0]     in_divisor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kat_pkg::SHARE_W-1:0]   out_share_q16,
  output logic                          out_key_found,
  output logic                          out_rejected,
  output logic [kat_pkg::ENTRIES_W-1:0] out_entries_used
);
  import kat_pkg::*;

  state_t state_r, state_nxt;

  // Latched request.
  req_t             req_r;
  logic [KEY_W-1:0] key_r;
  logic [AMT_W-1:0] amt_r;
  logic [DIV_W-1:0] div_r;

  // Search bookkeeping.
  logic [CNT_W-1:0] scan_r;
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [SUM_W-1:0] hit_sum_r;

  // Result under construction and the table count.
  logic               found_r;
  logic               rej_r;
  logic [SHARE_W-1:0] share_r;
  logic [CNT_W-1:0]   used_r;

  // Output stage.
  logic                 out_valid_r;
  logic [SHARE_W-1:0]   out_share_r;
  logic                 out_found_r;
  logic                 out_rej_r;
  logic [ENTRIES_W-1:0] out_used_r;

  mem_req_t           mem_req;
  slot_t              rd_data;
  logic               div_start;
  logic               div_done;
  logic [SHARE_W-1:0] div_quo;

  logic             accept;
  logic             early_rej;
  logic             early_done;
  req_t             in_req;
  logic             issue;
  logic             hit;
  logic             miss;
  logic             room;
  logic [CNT_W-1:0] last_cnt;
  logic [SUM_W:0]   acc_sum;
  logic [SUM_W-1:0] sat_sum;
  logic             out_load;

  assign in_req   = req_t'(in_req_type);
  assign accept   = in_valid && !in_stall;
  // Key zero on any real request, or a zero divisor on a query, is refused.
  assign early_rej = (in_req != REQ_NONE) &&
                     ((in_entry_key == '0) || ((in_req == REQ_QRY) && (in_divisor == '0)));
  assign early_done = early_rej || (in_req == REQ_NONE);

  // The search issues one read per cycle and compares the returned data in the following cycle.
  assign issue    = (scan_r < used_r);
  assign hit      = pend_v_r && (rd_data.key == key_r);
  assign miss     = !issue && !pend_v_r;
  assign room     = (used_r < CNT_W'(CAPACITY));
  assign last_cnt = used_r - CNT_W'(1);
  assign acc_sum  = {1'b0, hit_sum_r} + {{(SUM_W + 1 - AMT_W){1'b0}}, amt_r};
  assign sat_sum  = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = early_done ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (found_r && (req_r == REQ_REM)) begin
          state_nxt = ST_MOVE;
        end else if (found_r && (req_r == REQ_QRY)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOVE: begin
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory accesses, divider start and input handshake.
  always_comb begin
    in_stall        = 1'b1;
    div_start       = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = scan_r[IDX_W-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = hit_idx_r;
    mem_req.wr_data = '{key: key_r, sum: sat_sum};
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SCAN: begin
        mem_req.rd_en = issue;
      end
      ST_ACT: begin
        case (req_r)
          REQ_ACC: begin
            if (found_r) begin
              mem_req.wr_en = 1'b1;
            end else if (room) begin
              // Append the new key in the first free slot.
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = used_r[IDX_W-1:0];
              mem_req.wr_data = '{key: key_r, sum: {{(SUM_W - AMT_W){1'b0}}, amt_r}};
            end
          end
          REQ_REM: begin
            // Fetch the last occupied slot to move it into the hole.
            mem_req.rd_en   = found_r;
            mem_req.rd_addr = last_cnt[IDX_W-1:0];
          end
          REQ_QRY: begin
            div_start = found_r;
          end
          default: begin
          end
        endcase
      end
      ST_MOVE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCAN) begin
        pend_v_r <= issue;
      end else begin
        pend_v_r <= 1'b0;
      end
      if ((state_r == ST_ACT) && (req_r == REQ_ACC) && !found_r && room) begin
        used_r <= used_r + CNT_W'(1);
      end else if (state_r == ST_MOVE) begin
        used_r <= last_cnt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req;
      key_r   <= in_entry_key;
      amt_r   <= in_add_amount;
      div_r   <= in_divisor;
      scan_r  <= '0;
      found_r <= 1'b0;
      share_r <= '0;
      rej_r   <= early_rej;
    end else begin
      if (state_r == ST_SCAN) begin
        scan_r     <= issue ? scan_r + CNT_W'(1) : scan_r;
        pend_idx_r <= scan_r[IDX_W-1:0];
        if (hit) begin
          found_r   <= 1'b1;
          hit_idx_r <= pend_idx_r;
          hit_sum_r <= rd_data.sum;
        end
      end
      if ((state_r == ST_ACT) && (req_r == REQ_ACC) && !found_r && !room) begin
        rej_r <= 1'b1;
      end
      if ((state_r == ST_DIV) && div_done) begin
        share_r <= div_quo;
      end
    end
    if (out_load) begin
      out_share_r <= share_r;
      out_found_r <= found_r;
      out_rej_r   <= rej_r;
      out_used_r  <= ENTRIES_W'(used_r);
    end
  end

  kat_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  kat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (hit_sum_r),
    .divisor  (div_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid        = out_valid_r;
  assign out_share_q16    = out_share_r;
  assign out_key_found    = out_found_r;
  assign out_rejected     = out_rej_r;
  assign out_entries_used = out_used_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |->
      ((used_r == $past(used_r) + CNT_W'(1)) || (used_r == $past(used_r) - CNT_W'(1))))
    else $error("entry count moved by more than one");

  a_found_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_key_found && out_rejected))
    else $error("result both found and rejected");

  a_share_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_share_q16 != '0)) |-> out_key_found)
    else $error("nonzero share for an absent key");
`endif

endmodule

// ===== tb/sv/keyed_accumulator_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_accumulator_table_test
// Self-checking bench for the keyed accumulator table. A behavioral copy of
// the key/sum table predicts every result. Directed cases, a fill to capacity
// with swap-removal, random traffic under several idle and stall mixes, and a
// long output hold-off are run in turn.
// ----------------------------------------------------------------------------
module keyed_accumulator_table_test;
  import kat_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 100;
  localparam int KEY_POOL      = 44;
  localparam int MAX_SEND_GAP  = 24;
  localparam int REPORT_LIMIT  = 10;

  // One result item as the block reports it.
  typedef struct packed {
    logic [SHARE_W-1:0]   share_q16;
    logic                 key_found;
    logic                 rejected;
    logic [ENTRIES_W-1:0] entries_used;
  } table_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = REQ_NONE;
  logic [KEY_W-1:0]     in_entry_key = '0;
  logic [AMT_W-1:0]     in_add_amount = '0;
  logic [DIV_W-1:0]     in_divisor = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SHARE_W-1:0]   out_share_q16;
  logic                 out_key_found;
  logic                 out_rejected;
  logic [ENTRIES_W-1:0] out_entries_used;

  // Shadow copy of the table, updated as each item is accepted.
  logic [KEY_W-1:0] tally_key [CAPACITY];
  logic [SUM_W-1:0] tally_sum [CAPACITY];
  int               tally_count;

  table_result_t    pending_results[$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  logic hold_arm = 1'b0;

  keyed_accumulator_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_key     (in_entry_key),
    .in_add_amount    (in_add_amount),
    .in_divisor       (in_divisor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_share_q16    (out_share_q16),
    .out_key_found    (out_key_found),
    .out_rejected     (out_rejected),
    .out_entries_used (out_entries_used)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result the block
  // must give for it. The key search runs over the occupied slots only.
  function automatic table_result_t apply_table_request(
      input req_t op, input logic [KEY_W-1:0] key,
      input logic [AMT_W-1:0] amount, input logic [DIV_W-1:0] dv);
    table_result_t          res;
    int                     slot;
    logic [SUM_W:0]         total;
    logic [SUM_W+FRAC_W-1:0] quotient;
    res = '0;
    slot = -1;
    for (int i = 0; i < tally_count; i++) begin
      if (slot < 0 && tally_key[i] == key) slot = i;
    end
    // Key zero is reserved as the empty marker, so it is refused for every
    // real request type; the unused type is simply ignored.
    if (op != REQ_NONE && key == '0) begin
      res.rejected = 1'b1;
    end else begin
      case (op)
        REQ_ACC: begin
          if (slot >= 0) begin
            total = {1'b0, tally_sum[slot]} + {{(SUM_W + 1 - AMT_W){1'b0}}, amount};
            tally_sum[slot] = total[SUM_W] ? '1 : total[SUM_W-1:0];
            res.key_found = 1'b1;
          end else if (tally_count < CAPACITY) begin
            tally_key[tally_count] = key;
            tally_sum[tally_count] = {{(SUM_W - AMT_W){1'b0}}, amount};
            tally_count++;
          end else begin
            res.rejected = 1'b1;
          end
        end
        REQ_REM: begin
          // Swap-remove: the last occupied entry fills the hole.
          if (slot >= 0) begin
            tally_key[slot] = tally_key[tally_count-1];
            tally_sum[slot] = tally_sum[tally_count-1];
            tally_key[tally_count-1] = '0;
            tally_sum[tally_count-1] = '0;
            tally_count--;
            res.key_found = 1'b1;
          end
        end
        REQ_QRY: begin
          if (dv == '0) begin
            res.rejected = 1'b1;
          end else if (slot >= 0) begin
            quotient = {tally_sum[slot], {FRAC_W{1'b0}}} /
                       {{(SUM_W + FRAC_W - DIV_W){1'b0}}, dv};
            res.share_q16 = (quotient >> SHARE_W) != 0 ? '1 : quotient[SHARE_W-1:0];
            res.key_found = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.entries_used = tally_count[ENTRIES_W-1:0];
    return res;
  endfunction

  // Offers one item after a random idle gap and waits until it is taken. The
  // valid line is only lowered when a gap is inserted, so back-to-back items
  // keep it high without a second assignment in the same step.
  task automatic send_request(input req_t op, input logic [KEY_W-1:0] key,
                              input logic [AMT_W-1:0] amount,
                              input logic [DIV_W-1:0] dv);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_entry_key  <= key;
    in_add_amount <= amount;
    in_divisor    <= dv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_table_request(op, key, amount, dv));
  endtask

  // Stops offering items and waits until every expected result has come.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string why, input table_result_t want,
                                 input table_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t mismatch (%s): expected share=%h found=%b rejected=%b used=%0d,",
               $realtime, why, want.share_q16, want.key_found, want.rejected,
               want.entries_used);
      $display("    got share=%h found=%b rejected=%b used=%0d",
               got.share_q16, got.key_found, got.rejected, got.entries_used);
    end
  endtask

  // Result side: checks each accepted result against the oldest expectation
  // and decides the stall for the next cycle. The long hold-off overrides the
  // random stall while its counter runs.
  always @(posedge clk) begin : result_check
    table_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.share_q16    = out_share_q16;
      got.key_found    = out_key_found;
      got.rejected     = out_rejected;
      got.entries_used = out_entries_used;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.share_q16 !== want.share_q16 || got.key_found !== want.key_found ||
            got.rejected !== want.rejected || got.entries_used !== want.entries_used) begin
          report_mismatch("wrong field", want, got);
        end
      end
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Counts out the long receiver hold-off once it has been armed.
  always @(posedge clk) begin : holdoff_counter
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Field extremes and every special case, starting from an empty table and
  // leaving it empty again.
  task automatic test_directed_cases();
    logic [KEY_W-1:0] kmax;
    logic [KEY_W-1:0] kalt;
    kmax = '1;
    kalt = 31'h2AAA_AAAA;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Key zero and divisor zero are refused without touching the table.
    send_request(REQ_ACC, '0, 31'd5, 31'd1);
    send_request(REQ_REM, '0, '0, '0);
    send_request(REQ_QRY, '0, '0, 31'd1);
    send_request(REQ_QRY, kmax, '0, '0);
    // The unused request type only reports the count.
    send_request(REQ_NONE, kmax, '1, '1);
    // Remove and query of an absent key.
    send_request(REQ_REM, kmax, '0, '0);
    send_request(REQ_QRY, kmax, '0, 31'd1);
    // Largest amounts drive the sum into saturation.
    send_request(REQ_ACC, kmax, '1, '0);
    send_request(REQ_ACC, kmax, '1, '0);
    send_request(REQ_QRY, kmax, '0, 31'd1);
    send_request(REQ_ACC, kmax, '1, '0);
    send_request(REQ_QRY, kmax, '0, '1);
    send_request(REQ_QRY, kmax, '0, 31'h0001_0000);
    send_request(REQ_ACC, 31'd1, '0, '0);
    send_request(REQ_ACC, 31'd1, 31'd1, '0);
    send_request(REQ_QRY, 31'd1, '0, 31'd3);
    send_request(REQ_QRY, 31'd1, '0, '1);
    send_request(REQ_ACC, kalt, 31'h5555_5555, '0);
    send_request(REQ_QRY, kalt, '0, 31'h5555_5555);
    // Removing the first slot moves the last entry down into it.
    send_request(REQ_REM, kmax, '0, '0);
    send_request(REQ_QRY, kalt, '0, kalt);
    send_request(REQ_REM, kalt, '0, '0);
    send_request(REQ_REM, 31'd1, '0, '0);
    send_request(REQ_REM, 31'd1, '0, '0);
    send_request(REQ_NONE, '0, '0, '0);
    wait_for_results();
  endtask

  // Fills all slots, hits the full-table refusal, then empties the table in
  // random order with a query after each removal that leaves the table nonempty.
  task automatic test_capacity_limits();
    logic [KEY_W-1:0] fill_keys [CAPACITY];
    logic [KEY_W-1:0] live_keys[$];
    logic [KEY_W-1:0] spare;
    int               pick;
    send_idle_pct = 36;
    recv_stall_pct = 36;
    // Bit 5 is set in every fill key and clear in the spare one, so all
    // keys are distinct and nonzero.
    for (int i = 0; i < CAPACITY; i++) begin
      fill_keys[i] = (KEY_W'($urandom) & 31'h7FFF_FFC0) | 31'h20 | KEY_W'(i);
      send_request(REQ_ACC, fill_keys[i], AMT_W'($urandom), '0);
    end
    spare = (KEY_W'($urandom) & 31'h7FFF_FFC0) | 31'h1F;
    send_request(REQ_ACC, spare, 31'd9, '0);
    send_request(REQ_QRY, spare, '0, 31'd7);
    send_request(REQ_ACC, fill_keys[5], AMT_W'($urandom), '0);
    send_request(REQ_QRY, fill_keys[CAPACITY-1], '0, DIV_W'($urandom) | 31'd1);
    send_request(REQ_REM, fill_keys[0], '0, '0);
    send_request(REQ_ACC, spare, 31'd9, '0);
    for (int i = 1; i < CAPACITY; i++) live_keys.push_back(fill_keys[i]);
    live_keys.push_back(spare);
    while (live_keys.size() != 0) begin
      pick = $urandom_range(live_keys.size() - 1);
      send_request(REQ_REM, live_keys[pick], '0, '0);
      live_keys.delete(pick);
      if (live_keys.size() != 0) begin
        send_request(REQ_QRY, live_keys[$urandom_range(live_keys.size() - 1)], '0,
                     DIV_W'($urandom_range(1, 1 << 20)));
      end
    end
    wait_for_results();
  endtask

  // Random requests, mostly on a pool of keys a little larger than the table
  // so that hits, appends, refusals and removals all keep happening.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count);
    req_t             op;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic [DIV_W-1:0] dv;
    int               pick;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45)      op = REQ_ACC;
      else if (pick < 65) op = REQ_REM;
      else if (pick < 96) op = REQ_QRY;
      else                op = REQ_NONE;
      pick = $urandom_range(99);
      if (pick < 2)      key = '0;
      else if (pick < 7) key = KEY_W'($urandom);
      else               key = key_pool[$urandom_range(KEY_POOL - 1)];
      pick = $urandom_range(9);
      case (pick)
        0:       amount = '0;
        1:       amount = '1;
        2, 3, 4: amount = AMT_W'($urandom);
        default: amount = AMT_W'($urandom_range(5000));
      endcase
      pick = $urandom_range(19);
      if (pick == 0)     dv = '0;
      else if (pick < 5) dv = DIV_W'($urandom_range(1, 16));
      else if (pick < 8) dv = DIV_W'(1) << $urandom_range(DIV_W - 1);
      else               dv = DIV_W'($urandom);
      send_request(op, key, amount, dv);
    end
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the output register and the stage before it fill and the input stalls.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_request(i % 3 == 2 ? REQ_QRY : REQ_ACC,
                   key_pool[$urandom_range(KEY_POOL - 1)],
                   AMT_W'($urandom_range(100000)), DIV_W'($urandom_range(1, 1000)));
    end
    wait_for_results();
  endtask

  initial begin : run_tests
    for (int i = 0; i < CAPACITY; i++) begin
      tally_key[i] = '0;
      tally_sum[i] = '0;
    end
    tally_count = 0;
    // The pool holds both extreme keys and otherwise random nonzero ones.
    key_pool[0] = '1;
    key_pool[1] = 31'd1;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (key_pool[i] == '0) key_pool[i] = 31'd2;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_capacity_limits();
    // Random phases: free flow, idle sender, stalling receiver, then both.
    test_random_traffic(0, 0, 280);
    test_random_traffic(72, 0, 280);
    test_random_traffic(0, 72, 280);
    test_random_traffic(36, 36, 280);
    test_output_holdoff();

    // Let any stray late result show up before deciding.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
